FILE: design/pcx_pkg.sv
// Shared types, codes and constants of the PCX stream decoder.
`default_nettype none
package pcx_pkg;

	// Header layout: byte offsets of the fields we keep.
	localparam logic [6:0] HB_VERSION   = 7'd1;
	localparam logic [6:0] HB_BPP       = 7'd3;
	localparam logic [6:0] HB_XMIN_LO   = 7'd4;
	localparam logic [6:0] HB_XMIN_HI   = 7'd5;
	localparam logic [6:0] HB_YMIN_LO   = 7'd6;
	localparam logic [6:0] HB_YMIN_HI   = 7'd7;
	localparam logic [6:0] HB_XMAX_LO   = 7'd8;
	localparam logic [6:0] HB_XMAX_HI   = 7'd9;
	localparam logic [6:0] HB_YMAX_LO   = 7'd10;
	localparam logic [6:0] HB_YMAX_HI   = 7'd11;
	localparam logic [6:0] HB_PLANES    = 7'd65;
	localparam logic [6:0] HB_LINE_LO   = 7'd66;
	localparam logic [6:0] HB_LINE_HI   = 7'd67;
	localparam logic [6:0] HB_LAST      = 7'd127;

	localparam logic [7:0] RUN_MARK     = 8'hC0;
	localparam logic [7:0] RUN_MASK     = 8'h3F;
	localparam logic [7:0] MAX_VERSION  = 8'd10;
	localparam logic [7:0] MAX_BPP      = 8'd32;
	localparam logic [7:0] MAX_PLANES   = 8'd32;

	localparam int TOTAL_W = 38;
	localparam int DIM_W   = 17;

	// Result kinds on the output word.
	localparam logic [1:0] KIND_DATA   = 2'd0;
	localparam logic [1:0] KIND_ACCEPT = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	// Command queue between front and back.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		CMD_HDR_OK  = 2'd0,
		CMD_HDR_BAD = 2'd1,
		CMD_RUN     = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t            op;
		logic [7:0]           data;
		logic [5:0]           count;
		logic [DIM_W-1:0]     width;
		logic [DIM_W-1:0]     height;
		logic [TOTAL_W-1:0]   total;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Front sequencer: normal byte intake, then the header-size multiply.
	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_MUL1 = 4'b0010,
		F_MUL2 = 4'b0100,
		F_PUSH = 4'b1000
	} front_state_t;

	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_DATA   = 3'b010,
		PH_DONE   = 3'b100
	} phase_t;

endpackage
`default_nettype wire

FILE: design/pcx_front.sv
// Front end: header parsing and check, RLE classification into queue commands.
`default_nettype none
module pcx_front
	import pcx_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       start_of_file,
	input  wire q_stat_t    q_stat,
	output logic            push,
	output cmd_t            push_cmd
);

	front_state_t fst_q;
	phase_t       phase_q;
	logic [6:0]   idx_q;
	logic         pend_q;
	logic [5:0]   run_q;

	logic [7:0]   version_q, bpp_q, planes_q;
	logic [15:0]  xmin_q, ymin_q, xmax_q, ymax_q, line_q;
	logic [22:0]  prod_s1;
	logic [TOTAL_W-1:0] total_s2;

	logic             accept, eff_hdr, eff_data, hdr_bad, marker;
	logic [6:0]       idx;
	logic [DIM_W-1:0] width, height;
	logic [38:0]      full_prod;

	assign in_stall = (fst_q != F_IDLE) || q_stat.full;
	assign accept   = in_valid && !in_stall;
	assign eff_hdr  = start_of_file || (phase_q == PH_HEADER);
	assign eff_data = !start_of_file && (phase_q == PH_DATA);
	assign idx      = start_of_file ? '0 : idx_q;
	assign marker   = (in_byte & RUN_MARK) == RUN_MARK;

	assign hdr_bad = (version_q > MAX_VERSION) || (bpp_q > MAX_BPP) ||
		(xmin_q > xmax_q) || (ymin_q > ymax_q) || (planes_q > MAX_PLANES);
	assign width  = {1'b0, xmax_q} - {1'b0, xmin_q} + 17'd1;
	assign height = {1'b0, ymax_q} - {1'b0, ymin_q} + 17'd1;
	assign full_prod = prod_s1 * line_q;

	always_comb begin
		push     = 1'b0;
		push_cmd = '0;
		push_cmd.op = CMD_RUN;
		if (fst_q == F_PUSH) begin
			push            = !q_stat.full;
			push_cmd.op     = CMD_HDR_OK;
			push_cmd.width  = width;
			push_cmd.height = height;
			push_cmd.total  = total_s2;
		end else if (accept) begin
			if (eff_hdr) begin
				if (idx == HB_LAST && hdr_bad) begin
					push        = 1'b1;
					push_cmd.op = CMD_HDR_BAD;
				end
			end else if (eff_data) begin
				push_cmd.data = in_byte;
				if (pend_q) begin
					push           = 1'b1;
					push_cmd.count = run_q;
				end else if (!marker) begin
					push           = 1'b1;
					push_cmd.count = 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fst_q   <= F_IDLE;
			phase_q <= PH_HEADER;
			idx_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			unique case (fst_q)
				F_IDLE: begin
					if (accept) begin
						if (eff_hdr) begin
							pend_q <= 1'b0;
							if (idx == HB_LAST) begin
								idx_q <= '0;
								if (hdr_bad) begin
									phase_q <= PH_DONE;
								end else begin
									phase_q <= PH_DATA;
									fst_q   <= F_MUL1;
								end
							end else begin
								idx_q   <= idx + 7'd1;
								phase_q <= PH_HEADER;
							end
						end else if (eff_data) begin
							if (pend_q) begin
								pend_q <= 1'b0;
							end else if (marker) begin
								pend_q <= 1'b1;
							end
						end
					end
				end
				F_MUL1: fst_q <= F_MUL2;
				F_MUL2: fst_q <= F_PUSH;
				F_PUSH: begin
					if (!q_stat.full) begin
						fst_q <= F_IDLE;
					end
				end
				default: fst_q <= F_IDLE;
			endcase
		end
	end

	// Header fields, run count and the size multiply: no reset needed.
	always_ff @(posedge clk) begin
		if (accept && eff_hdr) begin
			unique case (idx)
				HB_VERSION: version_q    <= in_byte;
				HB_BPP:     bpp_q        <= in_byte;
				HB_XMIN_LO: xmin_q[7:0]  <= in_byte;
				HB_XMIN_HI: xmin_q[15:8] <= in_byte;
				HB_YMIN_LO: ymin_q[7:0]  <= in_byte;
				HB_YMIN_HI: ymin_q[15:8] <= in_byte;
				HB_XMAX_LO: xmax_q[7:0]  <= in_byte;
				HB_XMAX_HI: xmax_q[15:8] <= in_byte;
				HB_YMAX_LO: ymax_q[7:0]  <= in_byte;
				HB_YMAX_HI: ymax_q[15:8] <= in_byte;
				HB_PLANES:  planes_q     <= in_byte;
				HB_LINE_LO: line_q[7:0]  <= in_byte;
				HB_LINE_HI: line_q[15:8] <= in_byte;
				default: ;
			endcase
		end
		if (accept && eff_data && !pend_q && marker) begin
			run_q <= in_byte[5:0];
		end
		// planes is at most 32 once the header passed the check
		if (fst_q == F_MUL1) begin
			prod_s1 <= height * planes_q[5:0];
		end
		if (fst_q == F_MUL2) begin
			total_s2 <= full_prod[TOTAL_W-1:0];
		end
	end

endmodule
`default_nettype wire

FILE: design/pcx_queue.sv
// Short command queue between the front and back halves.
`default_nettype none
module pcx_queue
	import pcx_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output cmd_t      head,
	output q_stat_t   q_stat
);

	cmd_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QAW:0]   cnt_q;

	assign head         = mem_q[rd_q];
	assign q_stat.full  = cnt_q == QDEPTH[QAW:0];
	assign q_stat.empty = cnt_q == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

FILE: design/pcx_back.sv
// Back end: header results and run expansion against the pixel-byte total.
`default_nettype none
module pcx_back
	import pcx_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        head,
	input  wire q_stat_t     q_stat,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       kind,
	output logic [7:0]       out_byte,
	output logic [DIM_W-1:0] image_width,
	output logic [DIM_W-1:0] image_height,
	output logic             last
);

	logic [TOTAL_W-1:0] left_q;
	logic [5:0]         cnt_q;
	logic               ov_q;

	logic       slot_free, work, emit, run_end;
	logic [6:0] cnt_next;

	assign slot_free = !ov_q || !out_stall;
	assign work      = !q_stat.empty && slot_free;
	assign cnt_next  = {1'b0, cnt_q} + 7'd1;

	always_comb begin
		pop     = 1'b0;
		emit    = 1'b0;
		run_end = (left_q == '0) || (head.count == cnt_q);
		if (work) begin
			unique case (head.op) inside
				CMD_HDR_OK, CMD_HDR_BAD: begin
					pop  = 1'b1;
					emit = 1'b1;
				end
				CMD_RUN: begin
					if (run_end) begin
						pop = 1'b1;
					end else begin
						emit = 1'b1;
						pop  = (cnt_next == {1'b0, head.count}) ||
							(left_q == {{(TOTAL_W-1){1'b0}}, 1'b1});
					end
				end
				default: pop = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q   <= 1'b0;
			left_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (slot_free) begin
				ov_q <= emit;
			end
			if (work) begin
				if (head.op == CMD_HDR_OK) begin
					left_q <= head.total;
				end else if (head.op == CMD_HDR_BAD) begin
					left_q <= '0;
				end else if (emit) begin
					left_q <= left_q - 1'b1;
				end
				if (pop) begin
					cnt_q <= '0;
				end else if (emit) begin
					cnt_q <= cnt_next[5:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (work && emit) begin
			out_byte     <= '0;
			image_width  <= '0;
			image_height <= '0;
			last         <= 1'b0;
			unique case (head.op)
				CMD_HDR_OK: begin
					kind         <= KIND_ACCEPT;
					image_width  <= head.width;
					image_height <= head.height;
				end
				CMD_HDR_BAD: kind <= KIND_REJECT;
				default: begin
					kind     <= KIND_DATA;
					out_byte <= head.data;
					last     <= left_q == {{(TOTAL_W-1){1'b0}}, 1'b1};
				end
			endcase
		end
	end

	assign out_valid = ov_q;

endmodule
`default_nettype wire

FILE: design/pcx_stream_decoder_unit.sv
// Top level of the streaming PCX run-length decoder.
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+---------------------------------------------
//  input   | in        | in_valid / in_stall   | in_byte, start_of_file
//  output  | out       | out_valid / out_stall | kind, out_byte, image_width, image_height,
//          |           |                       | last
//
// Flow: a literal byte is taken each cycle unless in_stall is high; a run of n copies keeps
//   the back busy until its n copies are out (a zero count or an exhausted total just pops
//   the run), and input flows on until the 4-entry command queue fills.
// After the 128th byte of an accepted header the input stalls through two multiply
//   stages for height * planes * bytes per line, then the header command push,
//   which waits for a free queue entry. A rejected header stalls for none of these.
// Reset (arst_n low) puts the parser at header byte 0 and empties the queue.
// out_stall holds the output register; the back waits while the front keeps
//   filling the queue.
`default_nettype none
module pcx_stream_decoder_unit
	import pcx_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,
	input  wire logic        start_of_file,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       kind,
	output logic [7:0]       out_byte,
	output logic [DIM_W-1:0] image_width,
	output logic [DIM_W-1:0] image_height,
	output logic             last
);

	// front -> queue -> back
	q_stat_t q_stat;
	cmd_t    push_cmd, head;
	logic    push, pop;

	// Front: header bytes, header check, run markers.
	pcx_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.start_of_file(start_of_file),
		.q_stat       (q_stat),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	pcx_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.q_stat  (q_stat)
	);

	// Back: owns the remaining pixel-byte count and drives the output word.
	pcx_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_stat      (q_stat),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.out_byte    (out_byte),
		.image_width (image_width),
		.image_height(image_height),
		.last        (last)
	);

	a_q_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue both full and empty");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	a_data_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_DATA) |-> (image_width == '0 && image_height == '0))
		else $error("data word carries dimensions");

	a_hdr_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind != KIND_DATA) |-> (!last && out_byte == '0))
		else $error("header word carries data");

endmodule
`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for the PCX stream decoder: header checks and run-length expansion.
`timescale 1ns / 100ps
module tb_top
	import pcx_pkg::*;
();

	// No-accept watchdog limit, set well above the receiver hold-off.
	localparam int STUCK_LIMIT = 3000;

	// One input word as queued for the driver.
	typedef struct packed {
		logic [7:0] b;
		logic       sof;
		logic       drain; // hold this word back until every expected result is in
	} feed_t;

	// One output word as predicted.
	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       data;
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic             last;
	} pcx_word_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [7:0]       in_byte = 8'd0;
	logic             start_of_file = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [1:0]       kind;
	logic [7:0]       out_byte;
	logic [DIM_W-1:0] image_width;
	logic [DIM_W-1:0] image_height;
	logic             last;

	feed_t     byte_feed[$];   // words still to be offered
	pcx_word_t want_words[$];  // predicted results, oldest first
	feed_t     next_feed;
	pcx_word_t head_word;
	bit        pause_next = 1'b0;
	int        mismatches = 0;
	int        cycles = 0;
	int        stuck_cycles = 0;
	int        hold_left = 0;
	bit        held_once = 1'b0;
	bit        quiet;

	// Decoder shadow state.
	phase_t      stage;
	logic [6:0]  hdr_pos;
	logic [7:0]  ver, bpp, planes;
	logic [15:0] x0, y0, x1, y1, line_len;
	logic [37:0] remaining;
	logic [5:0]  rep_count;
	logic        rep_armed;

	pcx_stream_decoder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.start_of_file(start_of_file),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.out_byte(out_byte),
		.image_width(image_width),
		.image_height(image_height),
		.last(last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	// Window with no random idling on either side.
	assign quiet = (cycles >= 20) && (cycles < 120);

	// ---------------------------------------------------------------
	// Prediction
	// ---------------------------------------------------------------

	task automatic push_word(input logic [1:0] k, input logic [7:0] d,
			input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h, input logic l);
		pcx_word_t x;
		x.kind = k;
		x.data = d;
		x.w    = w;
		x.h    = h;
		x.last = l;
		want_words.push_back(x);
	endtask

	// n copies of b, cut at the pixel total; the copy that hits zero is the last.
	task automatic copy_out(input logic [7:0] b, input logic [5:0] n);
		int i;
		for (i = 0; i < n && remaining != '0; i++) begin
			remaining = remaining - 38'd1;
			push_word(KIND_DATA, b, '0, '0, remaining == '0);
		end
		if (remaining == '0) begin
			stage = PH_DONE;
		end
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic sof);
		logic [DIM_W-1:0] w, h;
		logic [63:0]      prod;
		// start of file wins over everything, including a pending run count
		if (sof) begin
			stage     = PH_HEADER;
			hdr_pos   = '0;
			rep_armed = 1'b0;
			rep_count = '0;
			remaining = '0;
		end
		case (stage)
		PH_HEADER: begin
			case (hdr_pos)
			HB_VERSION: ver = b;
			HB_BPP:     bpp = b;
			HB_XMIN_LO: x0[7:0] = b;
			HB_XMIN_HI: x0[15:8] = b;
			HB_YMIN_LO: y0[7:0] = b;
			HB_YMIN_HI: y0[15:8] = b;
			HB_XMAX_LO: x1[7:0] = b;
			HB_XMAX_HI: x1[15:8] = b;
			HB_YMAX_LO: y1[7:0] = b;
			HB_YMAX_HI: y1[15:8] = b;
			HB_PLANES:  planes = b;
			HB_LINE_LO: line_len[7:0] = b;
			HB_LINE_HI: line_len[15:8] = b;
			default: ;
			endcase
			if (hdr_pos != HB_LAST) begin
				hdr_pos = hdr_pos + 7'd1;
			end else begin
				hdr_pos = '0;
				if (ver > MAX_VERSION || bpp > MAX_BPP || x0 > x1 || y0 > y1 ||
						planes > MAX_PLANES) begin
					push_word(KIND_REJECT, 8'd0, '0, '0, 1'b0);
					stage = PH_DONE;
				end else begin
					w = {1'b0, x1} - {1'b0, x0} + 17'd1;
					h = {1'b0, y1} - {1'b0, y0} + 17'd1;
					push_word(KIND_ACCEPT, 8'd0, w, h, 1'b0);
					prod = h;
					prod = prod * planes;
					prod = prod * line_len;
					remaining = prod[37:0];
					rep_armed = 1'b0;
					rep_count = '0;
					stage = (remaining == '0) ? PH_DONE : PH_DATA;
				end
			end
		end
		PH_DATA: begin
			if (rep_armed) begin
				rep_armed = 1'b0;
				copy_out(b, rep_count);
				rep_count = '0;
			end else if ((b & RUN_MARK) == RUN_MARK) begin
				rep_count = b[5:0];
				rep_armed = 1'b1;
			end else begin
				copy_out(b, 6'd1);
			end
		end
		default: ; // done: ignore until start of file
		endcase
	endtask

	// ---------------------------------------------------------------
	// Driver: offers queued words, predicts each one at acceptance
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid      <= 1'b0;
			in_byte       <= 8'd0;
			start_of_file <= 1'b0;
			stage     = PH_HEADER;
			hdr_pos   = '0;
			ver       = '0;
			bpp       = '0;
			planes    = '0;
			x0        = '0;
			y0        = '0;
			x1        = '0;
			y1        = '0;
			line_len  = '0;
			remaining = '0;
			rep_count = '0;
			rep_armed = 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				decode_byte(in_byte, start_of_file);
			end
			// a stalled word stays put; otherwise pick the next one or idle
			if (!in_valid || !in_stall) begin
				if (byte_feed.size() != 0 &&
						(!byte_feed[0].drain || want_words.size() == 0) &&
						(quiet || $urandom_range(99) >= 8)) begin
					next_feed = byte_feed.pop_front();
					in_valid      <= 1'b1;
					in_byte       <= next_feed.b;
					start_of_file <= next_feed.sof;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Receiver: random stalls plus one long hold-off so the block backs up
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			held_once <= 1'b0;
		end else begin
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (!held_once && stage == PH_DATA && want_words.size() >= 2) begin
				held_once <= 1'b1;
				hold_left <= 300;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !quiet && ($urandom_range(99) < 8);
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor and checker
	// ---------------------------------------------------------------
	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %0h, want %0h (cycle %0d)", what, got, want, cycles);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (want_words.size() == 0) begin
				flag_mismatch("unexpected word, kind", kind, 0);
			end else begin
				head_word = want_words.pop_front();
				if (kind !== head_word.kind)
					flag_mismatch("kind", kind, head_word.kind);
				if (out_byte !== head_word.data)
					flag_mismatch("out_byte", out_byte, head_word.data);
				if (image_width !== head_word.w)
					flag_mismatch("image_width", image_width, head_word.w);
				if (image_height !== head_word.h)
					flag_mismatch("image_height", image_height, head_word.h);
				if (last !== head_word.last)
					flag_mismatch("last", last, head_word.last);
			end
		end
	end

	// Watchdog: nothing accepted on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", STUCK_LIMIT);
				$display("tb_top: errors");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus builders
	// ---------------------------------------------------------------
	task automatic add_byte(input logic [7:0] b, input logic sof);
		feed_t x;
		x.b     = b;
		x.sof   = sof;
		x.drain = pause_next;
		pause_next = 1'b0;
		byte_feed.push_back(x);
	endtask

	// 128-byte header with random filler; total is the pixel-byte count if it passes.
	task automatic add_header(input logic [7:0] v, input logic [7:0] bits,
			input logic [15:0] xa, input logic [15:0] ya,
			input logic [15:0] xb, input logic [15:0] yb,
			input logic [7:0] pl, input logic [15:0] ll,
			input logic sof0, output longint total);
		logic [7:0] i;
		logic [6:0] pos;
		logic [7:0] b;
		longint     hgt;
		for (i = 0; i < 128; i++) begin
			pos = i[6:0];
			b = 8'($urandom);
			case (pos)
			HB_VERSION: b = v;
			HB_BPP:     b = bits;
			HB_XMIN_LO: b = xa[7:0];
			HB_XMIN_HI: b = xa[15:8];
			HB_YMIN_LO: b = ya[7:0];
			HB_YMIN_HI: b = ya[15:8];
			HB_XMAX_LO: b = xb[7:0];
			HB_XMAX_HI: b = xb[15:8];
			HB_YMAX_LO: b = yb[7:0];
			HB_YMAX_HI: b = yb[15:8];
			HB_PLANES:  b = pl;
			HB_LINE_LO: b = ll[7:0];
			HB_LINE_HI: b = ll[15:8];
			default: ;
			endcase
			add_byte(b, sof0 && (i == 0));
		end
		if (v > MAX_VERSION || bits > MAX_BPP || xa > xb || ya > yb || pl > MAX_PLANES) begin
			total = 0;
		end else begin
			hgt = yb;
			hgt = hgt - ya + 1;
			total = hgt * pl * ll;
		end
	endtask

	// ---------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------
	initial begin
		longint      tot;
		longint      k;
		logic [7:0]  rv, rb, rp;
		logic [15:0] rx0, ry0, rx1, ry1;

		// File one, no start marker: reset alone arms the header parser.
		// Limits that still pass: version 10, 32 bpp; 1 line x 4 planes x 12 bytes.
		add_header(MAX_VERSION, MAX_BPP, 16'd0, 16'd7, 16'd99, 16'd7, 8'd4, 16'd12,
			1'b0, tot);
		add_byte(8'h00, 1'b0);
		add_byte(8'hBF, 1'b0);
		add_byte(8'hC0, 1'b0); // zero count swallows the next byte
		add_byte(8'h55, 1'b0);
		add_byte(8'hC2, 1'b0);
		add_byte(8'hFF, 1'b0);
		// literals, leaving 14 bytes of the total for the final run
		for (k = 0; k < tot - 18; k++) begin
			add_byte(8'($urandom_range(8'hBF)), 1'b0);
		end
		add_byte(8'hFF, 1'b0);
		add_byte(8'hAA, 1'b0); // 63 copies, only 14 fit
		add_byte(8'h01, 1'b0); // after done

		// File two, once the block has drained: one failed check, or a
		// zero-plane 65536 x 65536 image that goes straight to done.
		rv  = 8'($urandom_range(10));
		rb  = 8'($urandom_range(32));
		rx0 = 16'd0;
		rx1 = 16'd3;
		ry0 = 16'd0;
		ry1 = 16'd3;
		rp  = 8'd1;
		case ($urandom_range(5))
		0: rv = 8'($urandom_range(255, 11));
		1: rb = 8'($urandom_range(255, 33));
		2: begin
			rx0 = 16'($urandom_range(16'hFFFF, 1));
			rx1 = 16'($urandom_range(rx0 - 16'd1));
		end
		3: begin
			ry0 = 16'($urandom_range(16'hFFFF, 1));
			ry1 = 16'($urandom_range(ry0 - 16'd1));
		end
		4: rp = 8'($urandom_range(255, 33));
		default: begin
			rx1 = 16'hFFFF;
			ry1 = 16'hFFFF;
			rp  = 8'd0;
		end
		endcase
		pause_next = 1'b1; // sender waits for the block to drain
		add_header(rv, rb, rx0, ry0, rx1, ry1, rp, 16'd1, 1'b1, tot);
		add_byte(8'h40, 1'b0); // ignored after reject or done

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_feed.size() != 0 || in_valid)
			@(posedge clk);
		while (want_words.size() != 0)
			@(posedge clk);
		// let any stray late words show up
		repeat (64) @(posedge clk);

		if (mismatches == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule

FILE: sim.f
design/pcx_pkg.sv
design/pcx_front.sv
design/pcx_queue.sv
design/pcx_back.sv
design/pcx_stream_decoder_unit.sv
verif/tb_top.sv
